// ===== hdl/dsp_pkg.sv =====
`timescale 1ns / 1ps

package dsp_pkg;

    // Field width of the step and period words on the input channel
    localparam int FIELD_BITS       = 32;

    // Defaults for the counter widths actually used inside
    localparam int DEF_STEP_BITS    = 32;
    localparam int DEF_PERIOD_BITS  = 32;

    // Item kind codes
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Input word
    typedef struct packed {
        logic                  kind;
        logic [FIELD_BITS-1:0] steps_left;
        logic [FIELD_BITS-1:0] period_left;
        logic [FIELD_BITS-1:0] steps_right;
        logic [FIELD_BITS-1:0] period_right;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic left_step_pin;
        logic right_step_pin;
        logic busy_res;
        logic done_res;
        logic accepted;
    } out_word_t;

    // Per-channel strobes from the top level
    typedef struct packed {
        logic load;
        logic tick;
    } chan_ctl_t;

    // Per-channel status back to the top level
    typedef struct packed {
        logic busy_now;
        logic busy_next;
        logic level_next;
    } chan_stat_t;

endpackage

// ===== hdl/dsp_chan.sv =====
`timescale 1ns / 1ps

module dsp_chan
    import dsp_pkg::*;
#(
    parameter int STEP_BITS   = DEF_STEP_BITS,
    parameter int PERIOD_BITS = DEF_PERIOD_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  chan_ctl_t              ctl,
    input  logic [STEP_BITS-1:0]   steps,
    input  logic [PERIOD_BITS-1:0] period,
    output chan_stat_t             stat
);

    logic [STEP_BITS:0]     half_reg,   half_next;
    logic [PERIOD_BITS-1:0] count_reg,  count_next;
    logic [PERIOD_BITS-1:0] reload_reg, reload_next;
    logic                   level_reg,  level_next;
    logic [PERIOD_BITS-1:0] period_eff;
    logic                   busy;
    logic                   expire;

    // Zero period behaves as one
    assign period_eff = (period == '0) ? {{(PERIOD_BITS-1){1'b0}}, 1'b1} : period;
    assign busy       = (half_reg != '0);
    assign expire     = (count_reg <= {{(PERIOD_BITS-1){1'b0}}, 1'b1});

    // Load on command; on a tick while busy, count down or toggle
    always_comb begin
        half_next   = half_reg;
        count_next  = count_reg;
        reload_next = reload_reg;
        level_next  = level_reg;
        if (ctl.load) begin
            half_next   = {steps, 1'b0};
            reload_next = period_eff;
            count_next  = period_eff;
        end else if (ctl.tick && busy) begin
            if (expire) begin
                level_next = ~level_reg;
                half_next  = half_reg - {{STEP_BITS{1'b0}}, 1'b1};
                count_next = reload_reg;
            end else begin
                count_next = count_reg - {{(PERIOD_BITS-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg   <= '0;
            count_reg  <= '0;
            reload_reg <= '0;
            level_reg  <= 1'b0;
        end else begin
            half_reg   <= half_next;
            count_reg  <= count_next;
            reload_reg <= reload_next;
            level_reg  <= level_next;
        end
    end

    assign stat.busy_now   = busy;
    assign stat.busy_next  = (half_next != '0);
    assign stat.level_next = level_next;

endmodule

// ===== hdl/dsp_out_stage.sv =====
`timescale 1ns / 1ps

module dsp_out_stage
    import dsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_word_t push_data,
    output logic      free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic      valid_reg, valid_next;
    out_word_t data_reg;

    // Room when empty or the held word leaves this cycle
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= push_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// ===== hdl/dual_stepper_pulse_generator.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake         | Word
// s_      | in        | s_valid / s_ready | in_word_t  (tick or move command)
// m_      | out       | m_valid / m_ready | out_word_t (pin levels and status)
//
// One word per cycle while the output register can take it; each accepted word's result is valid in the next cycle.
// State updates and the result are computed in the accept cycle and the
// result sits in a single output register.
// s_ready is high while that register is empty or being drained.
// Reset (aresetn low, synchronous) clears both channels and the output valid.

module dual_stepper_pulse_generator
    import dsp_pkg::*;
#(
    parameter int STEP_BITS   = DEF_STEP_BITS,
    parameter int PERIOD_BITS = DEF_PERIOD_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic       s_fire;
    logic       is_cmd;
    logic       was_busy;
    logic       busy_after;
    chan_ctl_t  ctl;
    chan_stat_t stat_l, stat_r;
    out_word_t  res;

    assign s_fire   = s_valid && s_ready;
    assign is_cmd   = (s_data.kind == KIND_CMD);
    assign was_busy = stat_l.busy_now || stat_r.busy_now;

    // Command only taken when idle; tick only acts while busy
    assign ctl.load = s_fire && is_cmd && !was_busy;
    assign ctl.tick = s_fire && !is_cmd && was_busy;

    dsp_chan #(
        .STEP_BITS   (STEP_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .steps   (s_data.steps_left[STEP_BITS-1:0]),
        .period  (s_data.period_left[PERIOD_BITS-1:0]),
        .stat    (stat_l)
    );

    dsp_chan #(
        .STEP_BITS   (STEP_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .steps   (s_data.steps_right[STEP_BITS-1:0]),
        .period  (s_data.period_right[PERIOD_BITS-1:0]),
        .stat    (stat_r)
    );

    // Result word from the post-update state
    assign busy_after         = stat_l.busy_next || stat_r.busy_next;
    assign res.left_step_pin  = stat_l.level_next;
    assign res.right_step_pin = stat_r.level_next;
    assign res.busy_res       = busy_after;
    assign res.done_res       = (ctl.load || ctl.tick) && !busy_after;
    assign res.accepted       = ctl.load;

    dsp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_fire),
        .push_data (res),
        .free      (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // A finished move never reports busy
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |-> !m_data.busy_res)
        else $error("done_res with busy_res set");

    // Command during a move is dropped
    a_busy_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && is_cmd && was_busy) |=> (m_valid && !m_data.accepted && m_data.busy_res))
        else $error("command taken while busy");

    // Tick while idle leaves everything quiet
    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !is_cmd && !was_busy) |=> (!m_data.done_res && !m_data.busy_res))
        else $error("idle tick changed status");

    // Busy only drops on an accepted word
    a_busy_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        ($fell(was_busy) && $past(aresetn)) |-> $past(s_fire))
        else $error("busy dropped without a word");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import dsp_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 4;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_e;

    // Tracks the motor channels and holds the pin/status words still owed
    class stepper_scoreboard;
        bit [DEF_STEP_BITS:0]     halves[2];
        bit [DEF_PERIOD_BITS-1:0] countdown[2];
        bit [DEF_PERIOD_BITS-1:0] reload[2];
        bit                       level[2];
        out_word_t                status_q[$];
        int errors;
        int n_moves;
        int n_done;
        int n_dropped;
        int n_idle_ticks;
        int n_compared;

        function bit busy();
            return halves[0] != 0 || halves[1] != 0;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void load_channel(int ch, bit [31:0] steps, bit [31:0] period);
            halves[ch]    = {steps, 1'b0};
            reload[ch]    = (period == 0) ? 1 : period;
            countdown[ch] = reload[ch];
        endfunction

        // One tick on one channel: toggle and reload when the countdown runs out
        function void tick_channel(int ch);
            if (halves[ch] == 0) return;
            if (countdown[ch] <= 1) begin
                level[ch]     = ~level[ch];
                halves[ch]    = halves[ch] - 1;
                countdown[ch] = reload[ch];
            end else begin
                countdown[ch] = countdown[ch] - 1;
            end
        endfunction

        // Advance the channels by one accepted word, queue the status it yields
        function void note_input(in_word_t w);
            out_word_t r;
            bit        was_busy;
            bit        finished;
            bit        took;
            was_busy = busy();
            finished = 1'b0;
            took     = 1'b0;
            if (w.kind == KIND_CMD) begin
                if (!was_busy) begin
                    load_channel(0, w.steps_left, w.period_left);
                    load_channel(1, w.steps_right, w.period_right);
                    took     = 1'b1;
                    finished = !busy();
                    n_moves++;
                end else begin
                    n_dropped++;
                end
            end else if (was_busy) begin
                tick_channel(0);
                tick_channel(1);
                finished = !busy();
            end else begin
                n_idle_ticks++;
            end
            if (finished) n_done++;
            r.left_step_pin  = level[0];
            r.right_step_pin = level[1];
            r.busy_res       = busy();
            r.done_res       = finished;
            r.accepted       = took;
            status_q.push_back(r);
        endfunction

        function void compare_bit(string name, logic want, logic got);
            if (got !== want) begin
                $error("%s: expected %0b, got %0b", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (status_q.size() == 0) begin
                $error("result word with nothing outstanding: %b", got);
                errors++;
                return;
            end
            want = status_q.pop_front();
            n_compared++;
            compare_bit("left_step_pin", want.left_step_pin, got.left_step_pin);
            compare_bit("right_step_pin", want.right_step_pin, got.right_step_pin);
            compare_bit("busy_res", want.busy_res, got.busy_res);
            compare_bit("done_res", want.done_res, got.done_res);
            compare_bit("accepted", want.accepted, got.accepted);
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    stepper_scoreboard sb = new();

    dual_stepper_pulse_generator u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Monitor both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Watchdog: too long without any word moving on either side
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver backpressure: the mode is picked anew at random
    ready_mode_e ready_mode = READY_ALWAYS;
    int          mode_left  = 50;
    int          rx_cycle   = 0;
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (mode_left == 0) begin
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: begin
                m_ready <= 1'b1;
            end
            READY_COIN: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            READY_SPARSE: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_ready <= (rx_cycle % 4 != 3);
            end
        endcase
    end

    function automatic in_word_t mk_word(logic kind, logic [31:0] sl, logic [31:0] pl,
                                         logic [31:0] sr, logic [31:0] pr);
        in_word_t w;
        w.kind         = kind;
        w.steps_left   = sl;
        w.period_left  = pl;
        w.steps_right  = sr;
        w.period_right = pr;
        return w;
    endfunction

    // Move sizes kept small so moves finish; a still channel gets any period
    function automatic void pick_move(output logic [31:0] steps, output logic [31:0] period);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            steps  = $urandom_range(0, 3);
            period = $urandom_range(0, 2);
        end else if (r < 95) begin
            steps  = $urandom_range(0, 12);
            period = $urandom_range(0, 6);
        end else begin
            steps  = $urandom_range(0, 40);
            period = $urandom_range(0, 3);
        end
        if (steps == 0 && $urandom_range(0, 2) == 0) period = $urandom();
    endfunction

    // Mostly ticks during a move and new moves when idle; some words get dropped
    function automatic in_word_t next_word(output bit useful);
        in_word_t w;
        w = mk_word(KIND_TICK, $urandom(), $urandom(), $urandom(), $urandom());
        if (!sb.busy()) begin
            useful = ($urandom_range(0, 99) < 88);
            if (useful) begin
                w.kind = KIND_CMD;
                pick_move(w.steps_left, w.period_left);
                pick_move(w.steps_right, w.period_right);
            end
        end else begin
            useful = ($urandom_range(0, 9) != 0);
            if (!useful) w.kind = KIND_CMD;
        end
        return w;
    endfunction

    // Present one word and hold it until taken; returns at the next falling edge
    task automatic drive_word(input in_word_t w);
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        in_word_t w;
        bit       useful;
        bit       paused;
        int       n_useful;
        int       burst;
        int       gap;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: idle tick, empty move, still channels, dropped commands,
        // period zero, one and larger, pins kept across moves
        drive_word(mk_word(KIND_TICK, '1, '1, '1, '1));
        drive_word(mk_word(KIND_CMD, 32'd0, '1, 32'd0, '1));
        drive_word(mk_word(KIND_CMD, 32'd1, 32'd0, 32'd0, '1));
        drive_word(mk_word(KIND_CMD, '1, '1, '1, '1));
        repeat (2) drive_word(mk_word(KIND_TICK, '0, '0, '0, '0));
        drive_word(mk_word(KIND_CMD, 32'd0, '1, 32'd1, 32'd3));
        repeat (3) drive_word(mk_word(KIND_TICK, '1, '0, '1, '0));
        drive_word(mk_word(KIND_CMD, '0, '0, '0, '0));
        repeat (3) drive_word(mk_word(KIND_TICK, '0, '1, '0, '1));
        drive_word(mk_word(KIND_CMD, 32'd2, 32'd1, 32'd1, 32'd2));
        repeat (4) drive_word(mk_word(KIND_TICK, '0, '0, '0, '0));
        drive_word(mk_word(KIND_TICK, '1, '1, '1, '1));
        drain_results();

        // Random bursts with gaps; one full drain halfway through
        n_useful = 0;
        paused   = 1'b0;
        while (n_useful < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                w = next_word(useful);
                drive_word(w);
                if (useful) n_useful++;
            end
            if (!paused && n_useful >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                drain_results();
            end else if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        sb.errors += sb.pending();

        $display("Covered %0d moves (%0d finished), %0d commands dropped while busy,",
                 sb.n_moves, sb.n_done, sb.n_dropped);
        $display("%0d ticks while idle; %0d status words compared.",
                 sb.n_idle_ticks, sb.n_compared);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
